// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the ready queue modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is held.
`define PRQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define PRQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/prq_pkg.sv =====
// ----------------------------------------------------------------------------
// prq_pkg
// Operation and status codes plus the controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package prq_pkg;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_PREEMPT = 2'd1,
    OP_POP     = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic start;      // latch request, read level record
    logic look;       // update level record, write or read slot
    logic capture;    // take popped task from slot memory
    logic load_out;   // move result into output register
    logic walk_step;  // step top level down by one
  } prq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pop_hit;    // pop finds a task at the top level
    logic walk_done;  // top level is occupied or zero
  } prq_stat_t;

endpackage

`default_nettype wire

// ===== hdl/priority_ready_queue_unit.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue_unit
// Task ready queue with one ring FIFO of task ids per priority level. Op 0
// appends a task at the tail of its level, op 1 inserts it ahead of the head,
// op 2 pops the head of the highest occupied level, op 3 does nothing. Every
// request beat returns exactly one result beat: a push reports done or full
// (full also for a level not below NUM_LEVELS), a pop on an empty queue
// returns task 0, priority 0 with status empty. Requests are handled one at a
// time by a sequencer around two single-port RAMs (level records, task slots):
// request latch with level record read, record update with slot write or
// read, task capture on a pop, result load; a pop that empties the top level
// walks it down before the next request is taken. A finished result waits in
// the output register while the next request is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_ready_queue_unit #(
  parameter int NUM_LEVELS  = 16,
  parameter int LEVEL_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [7:0] task_id,
  input  logic [3:0] priority_req,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] popped_task,
  output logic [3:0] popped_priority,
  output logic [1:0] status
);

  prq_pkg::prq_cmd_t  cmd;
  prq_pkg::prq_stat_t stat;

  prq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  prq_dpath #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .op              (op),
    .task_id         (task_id),
    .priority_req    (priority_req),
    .popped_task     (popped_task),
    .popped_priority (popped_priority),
    .status          (status)
  );

endmodule

`default_nettype wire

// ===== hdl/prq_ram.sv =====
// ----------------------------------------------------------------------------
// prq_ram
// Single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== hdl/prq_ctrl.sv =====
// ----------------------------------------------------------------------------
// prq_ctrl
// Sequencer for the ready queue: request intake, level update, slot read,
// result hand-off and the top level walk after a pop empties a level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module prq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  prq_pkg::prq_stat_t  stat,
  output prq_pkg::prq_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_READ,
    S_DONE,
    S_WALK
  } state_t;

  state_t state;

  // Output register can take a beat this cycle
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  assign in_stall = (state != S_IDLE);

  // Commands decoded from state
  always_comb begin
    cmd.start     = (state == S_IDLE) && in_valid;
    cmd.look      = (state == S_LOOK);
    cmd.capture   = (state == S_READ);
    cmd.load_out  = (state == S_DONE) && out_free;
    cmd.walk_step = (state == S_WALK) && !stat.walk_done;
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_LOOK;
        end
        S_LOOK: begin
          state <= stat.pop_hit ? S_READ : S_DONE;
        end
        S_READ: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state <= stat.walk_done ? S_IDLE : S_WALK;
        end
        S_WALK: begin
          if (stat.walk_done) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PRQ_ASSERT(a_load_when_free, clk, rst, cmd.load_out |-> !(out_valid && out_stall), "result overwrote a waiting beat")
  `PRQ_ASSERT(a_read_after_hit, clk, rst, (state == S_READ) |-> $past(stat.pop_hit), "slot read without a pop hit")
  `PRQ_ASSERT_ALWAYS(a_valid_from_done, clk, $rose(out_valid) |-> $past(state == S_DONE), "output valid rose outside result hand-off")

endmodule

`default_nettype wire

// ===== hdl/prq_dpath.sv =====
// ----------------------------------------------------------------------------
// prq_dpath
// Ready queue datapath: request registers, level record RAM (head, tail,
// count), slot RAM, per-level occupied bits, top level and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module prq_dpath #(
  parameter int NUM_LEVELS  = 16,
  parameter int LEVEL_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  prq_pkg::prq_cmd_t  cmd,
  output prq_pkg::prq_stat_t stat,
  input  logic [1:0]         op,
  input  logic [7:0]         task_id,
  input  logic [3:0]         priority_req,
  output logic [7:0]         popped_task,
  output logic [3:0]         popped_priority,
  output logic [1:0]         status
);

  localparam int LVL_W   = $clog2(NUM_LEVELS);
  localparam int LVL_CNT = 1 << LVL_W;
  localparam int SLOT_W  = $clog2(LEVEL_DEPTH);
  localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
  localparam int REC_W   = 2 * SLOT_W + CNT_W;
  localparam int SADDR_W = LVL_W + SLOT_W;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(LEVEL_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(LEVEL_DEPTH);
  localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);

  // Request registers
  prq_pkg::op_t      op_q;
  logic [7:0]        task_q;
  logic [LVL_W-1:0]  lvl_q;
  logic              in_range_q;

  // Control state
  logic [LVL_W-1:0]   top;
  logic [LVL_CNT-1:0] occupied;

  // Result registers
  logic [7:0]           res_task;
  logic [3:0]           res_prio;
  prq_pkg::status_t     res_status;

  // RAM ports
  logic               lvl_we;
  logic [LVL_W-1:0]   lvl_addr;
  logic [REC_W-1:0]   lvl_wdata;
  logic [REC_W-1:0]   lvl_rdata;
  logic               slot_we;
  logic [SADDR_W-1:0] slot_addr;
  logic [7:0]         slot_rdata;

  // Working values for the update step
  logic              is_pop;
  logic              is_push;
  logic [LVL_W-1:0]  start_lvl;
  logic [LVL_W-1:0]  cur_lvl;
  logic [REC_W-1:0]  rec;
  logic [SLOT_W-1:0] rec_head;
  logic [SLOT_W-1:0] rec_tail;
  logic [CNT_W-1:0]  rec_cnt;
  logic [SLOT_W-1:0] head_prev;
  logic [SLOT_W-1:0] head_next;
  logic [SLOT_W-1:0] tail_next;
  logic [SLOT_W-1:0] push_slot;
  logic              push_ok;
  logic              pop_hit;

  assign start_lvl = (prq_pkg::op_t'(op) == prq_pkg::OP_POP) ? top : LVL_W'(priority_req);

  assign is_pop  = (op_q == prq_pkg::OP_POP);
  assign is_push = (op_q == prq_pkg::OP_PUSH) || (op_q == prq_pkg::OP_PREEMPT);
  assign cur_lvl = is_pop ? top : lvl_q;

  // An unoccupied level reads as an empty ring at slot zero
  assign rec      = occupied[cur_lvl] ? lvl_rdata : '0;
  assign rec_head = rec[REC_W-1 -: SLOT_W];
  assign rec_tail = rec[CNT_W+SLOT_W-1 -: SLOT_W];
  assign rec_cnt  = rec[CNT_W-1:0];

  // Ring index wrap, depth need not be a power of two
  assign head_prev = (rec_head == '0) ? SLOT_LAST : rec_head - 1'b1;
  assign head_next = (rec_head == SLOT_LAST) ? '0 : rec_head + 1'b1;
  assign tail_next = (rec_tail == SLOT_LAST) ? '0 : rec_tail + 1'b1;

  assign push_ok   = is_push && in_range_q && (rec_cnt != CNT_FULL);
  assign pop_hit   = is_pop && occupied[top];
  assign push_slot = (op_q == prq_pkg::OP_PREEMPT) ? head_prev : rec_tail;

  // Level record update
  always_comb begin
    if (pop_hit) begin
      lvl_wdata = {head_next, rec_tail, rec_cnt - 1'b1};
    end else if (op_q == prq_pkg::OP_PREEMPT) begin
      lvl_wdata = {head_prev, rec_tail, rec_cnt + 1'b1};
    end else begin
      lvl_wdata = {rec_head, tail_next, rec_cnt + 1'b1};
    end
  end

  assign lvl_we    = cmd.look && (push_ok || pop_hit);
  assign lvl_addr  = cmd.start ? start_lvl : cur_lvl;
  assign slot_we   = cmd.look && push_ok;
  assign slot_addr = {cur_lvl, (pop_hit ? rec_head : push_slot)};

  prq_ram #(
    .WIDTH (REC_W),
    .DEPTH (LVL_CNT)
  ) u_level_ram (
    .clk   (clk),
    .we    (lvl_we),
    .addr  (lvl_addr),
    .wdata (lvl_wdata),
    .rdata (lvl_rdata)
  );

  prq_ram #(
    .WIDTH (8),
    .DEPTH (LVL_CNT << SLOT_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .addr  (slot_addr),
    .wdata (task_q),
    .rdata (slot_rdata)
  );

  // Top level and occupied bits
  always_ff @(posedge clk) begin
    if (rst) begin
      top      <= '0;
      occupied <= '0;
    end else begin
      if (cmd.look && push_ok) begin
        occupied[lvl_q] <= 1'b1;
        if (lvl_q > top) top <= lvl_q;
      end
      if (cmd.look && pop_hit && (rec_cnt == CNT_ONE)) begin
        occupied[top] <= 1'b0;
      end
      if (cmd.walk_step) begin
        top <= top - 1'b1;
      end
    end
  end

  // Request, result and output payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_q       <= prq_pkg::op_t'(op);
      task_q     <= task_id;
      lvl_q      <= LVL_W'(priority_req);
      in_range_q <= (32'(priority_req) < 32'(NUM_LEVELS));
    end
    if (cmd.look) begin
      res_task <= '0;
      res_prio <= pop_hit ? 4'(top) : 4'd0;
      if (is_pop) begin
        res_status <= pop_hit ? prq_pkg::ST_DONE : prq_pkg::ST_EMPTY;
      end else if (is_push) begin
        res_status <= push_ok ? prq_pkg::ST_DONE : prq_pkg::ST_FULL;
      end else begin
        res_status <= prq_pkg::ST_DONE;
      end
    end
    if (cmd.capture) begin
      res_task <= slot_rdata;
    end
    if (cmd.load_out) begin
      popped_task     <= res_task;
      popped_priority <= res_prio;
      status          <= res_status;
    end
  end

  assign stat.pop_hit   = pop_hit;
  assign stat.walk_done = (top == '0) || occupied[top];

  `PRQ_ASSERT(a_top_settled, clk, rst, cmd.start |-> stat.walk_done, "request taken before top level settled")
  `PRQ_ASSERT(a_pop_nonzero, clk, rst, (cmd.look && pop_hit) |-> (rec_cnt != '0), "occupied level with zero count")
  `PRQ_ASSERT(a_push_bounds, clk, rst, (cmd.look && push_ok) |-> ((32'(lvl_q) < 32'(NUM_LEVELS)) && (rec_cnt < CNT_FULL)), "push past level bounds")

endmodule

`default_nettype wire

// ===== test/priority_ready_queue_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ready_queue_unit_test
// Self-checking bench for the priority ready queue. A short table of requests
// covers reset state, empty pops, both push kinds, a full level and the top
// level walking down. A long random run follows, made of fill, drain and even
// phases with bursty requests and a stalling result side. Every result beat is
// checked field by field against its table row or an in-bench model of the per-level rings.
// ----------------------------------------------------------------------------

module priority_ready_queue_unit_test;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 6;
  localparam int LEVELS         = 16;
  localparam int DEPTH          = 16;
  localparam int RANDOM_ITEMS   = 1750;
  localparam int TAIL_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_LIMIT    = 40;

  // Request mix of one random phase
  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;
  // Result-side stall pattern
  typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_COMB} rx_mode_t;

  typedef struct packed {
    logic [7:0]       tid;
    logic [3:0]       lvl;
    prq_pkg::status_t st;
  } queue_result_t;

  // One row of directed requests; tid counts up across repeats
  typedef struct packed {
    prq_pkg::op_t     code;
    logic [7:0]       tid;
    logic [3:0]       lvl;
    int               reps;
    logic             typed;
    logic [7:0]       want_tid;
    logic [3:0]       want_lvl;
    prq_pkg::status_t want_st;
  } step_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] op = prq_pkg::OP_NONE;
  logic [7:0] task_id = 8'd0;
  logic [3:0] priority_req = 4'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] popped_task;
  logic [3:0] popped_priority;
  logic [1:0] status;

  // Model of the queue contents
  logic [7:0] ring_slot [LEVELS][DEPTH];
  int         ring_head [LEVELS];
  int         ring_tail [LEVELS];
  int         ring_fill [LEVELS];
  int         tasks_held;
  int         top_lvl;

  queue_result_t pending_results[$];

  int mismatch_count;
  int results_seen;
  int beats_sent;
  int pops_served;
  int full_drops;
  int empty_pops;
  int idle_cycles;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left;

  step_row_t directed_rows [23] = '{
    // pop right after reset
    '{prq_pkg::OP_POP,     8'h00, 4'd0,  1,  1'b1, 8'h00, 4'd0,  prq_pkg::ST_EMPTY},
    // unused op
    '{prq_pkg::OP_NONE,    8'hFF, 4'd15, 1,  1'b1, 8'h00, 4'd0,  prq_pkg::ST_DONE},
    '{prq_pkg::OP_PUSH,    8'h00, 4'd0,  1,  1'b1, 8'h00, 4'd0,  prq_pkg::ST_DONE},
    '{prq_pkg::OP_PUSH,    8'hFF, 4'd15, 1,  1'b1, 8'h00, 4'd0,  prq_pkg::ST_DONE},
    '{prq_pkg::OP_PREEMPT, 8'hAA, 4'd15, 1,  1'b1, 8'h00, 4'd0,  prq_pkg::ST_DONE},
    // preempted one first
    '{prq_pkg::OP_POP,     8'h00, 4'd0,  1,  1'b1, 8'hAA, 4'd15, prq_pkg::ST_DONE},
    '{prq_pkg::OP_POP,     8'h00, 4'd0,  1,  1'b1, 8'hFF, 4'd15, prq_pkg::ST_DONE},
    // task 0 at level 0
    '{prq_pkg::OP_POP,     8'h00, 4'd0,  1,  1'b1, 8'h00, 4'd0,  prq_pkg::ST_DONE},
    '{prq_pkg::OP_POP,     8'h00, 4'd0,  1,  1'b1, 8'h00, 4'd0,  prq_pkg::ST_EMPTY},
    // fill level 7
    '{prq_pkg::OP_PUSH,    8'h10, 4'd7,  16, 1'b1, 8'h00, 4'd0,  prq_pkg::ST_DONE},
    '{prq_pkg::OP_PUSH,    8'h55, 4'd7,  1,  1'b1, 8'h00, 4'd0,  prq_pkg::ST_FULL},
    '{prq_pkg::OP_PREEMPT, 8'h56, 4'd7,  1,  1'b1, 8'h00, 4'd0,  prq_pkg::ST_FULL},
    '{prq_pkg::OP_POP,     8'h00, 4'd0,  1,  1'b1, 8'h10, 4'd7,  prq_pkg::ST_DONE},
    // head steps back
    '{prq_pkg::OP_PREEMPT, 8'h77, 4'd7,  1,  1'b1, 8'h00, 4'd0,  prq_pkg::ST_DONE},
    '{prq_pkg::OP_PUSH,    8'h33, 4'd15, 1,  1'b1, 8'h00, 4'd0,  prq_pkg::ST_DONE},
    '{prq_pkg::OP_PUSH,    8'h44, 4'd1,  1,  1'b1, 8'h00, 4'd0,  prq_pkg::ST_DONE},
    '{prq_pkg::OP_PREEMPT, 8'h22, 4'd1,  1,  1'b1, 8'h00, 4'd0,  prq_pkg::ST_DONE},
    // walks 15 down to 7
    '{prq_pkg::OP_POP,     8'h00, 4'd0,  1,  1'b1, 8'h33, 4'd15, prq_pkg::ST_DONE},
    '{prq_pkg::OP_POP,     8'h00, 4'd0,  1,  1'b1, 8'h77, 4'd7,  prq_pkg::ST_DONE},
    // drain 7, walk to 1
    '{prq_pkg::OP_POP,     8'h00, 4'd0,  15, 1'b0, 8'h00, 4'd0,  prq_pkg::ST_DONE},
    '{prq_pkg::OP_POP,     8'h00, 4'd0,  1,  1'b0, 8'h00, 4'd0,  prq_pkg::ST_DONE},
    '{prq_pkg::OP_POP,     8'h00, 4'd0,  1,  1'b0, 8'h00, 4'd0,  prq_pkg::ST_DONE},
    '{prq_pkg::OP_POP,     8'h00, 4'd0,  1,  1'b1, 8'h00, 4'd0,  prq_pkg::ST_EMPTY}
  };

  priority_ready_queue_unit #(
    .NUM_LEVELS (LEVELS),
    .LEVEL_DEPTH(DEPTH)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .task_id        (task_id),
    .priority_req   (priority_req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .popped_task    (popped_task),
    .popped_priority(popped_priority),
    .status         (status)
  );

  always #HALF_PERIOD clk = ~clk;

  // Apply one request to the ring model and return the result it yields
  function automatic queue_result_t predict_request(prq_pkg::op_t code, logic [7:0] tid,
                                                    logic [3:0] lvl);
    queue_result_t res;
    int src;
    res = '{8'd0, 4'd0, prq_pkg::ST_DONE};
    case (code)
      prq_pkg::OP_PUSH, prq_pkg::OP_PREEMPT: begin
        if (int'(lvl) >= LEVELS || ring_fill[lvl] >= DEPTH) begin
          res.st = prq_pkg::ST_FULL;
        end else begin
          if (code == prq_pkg::OP_PREEMPT) begin
            ring_head[lvl] = (ring_head[lvl] + DEPTH - 1) % DEPTH;
            ring_slot[lvl][ring_head[lvl]] = tid;
          end else begin
            ring_slot[lvl][ring_tail[lvl]] = tid;
            ring_tail[lvl] = (ring_tail[lvl] + 1) % DEPTH;
          end
          ring_fill[lvl]++;
          tasks_held++;
          if (int'(lvl) > top_lvl) top_lvl = int'(lvl);
        end
      end
      prq_pkg::OP_POP: begin
        src = top_lvl;
        if (tasks_held == 0 || ring_fill[src] == 0) begin
          res.st = prq_pkg::ST_EMPTY;
        end else begin
          res.tid = ring_slot[src][ring_head[src]];
          res.lvl = 4'(src);
          ring_head[src] = (ring_head[src] + 1) % DEPTH;
          ring_fill[src]--;
          tasks_held--;
          // step down to the next occupied level, or 0
          while (top_lvl != 0 && ring_fill[top_lvl] == 0) top_lvl--;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t: result %0d %s got %0h expected %0h", $realtime, results_seen, what,
               got, want);
    mismatch_count++;
  endtask

  // Drive one request beat and hold it until taken
  task automatic send_request(input prq_pkg::op_t code, input logic [7:0] tid,
                              input logic [3:0] lvl, input logic typed,
                              input queue_result_t want);
    queue_result_t predicted;
    in_valid     <= 1'b1;
    op           <= code;
    task_id      <= tid;
    priority_req <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_request(code, tid, lvl);
    pending_results.push_back(typed ? want : predicted);
    beats_sent++;
    if (code == prq_pkg::OP_POP && predicted.st == prq_pkg::ST_DONE) pops_served++;
    if (predicted.st == prq_pkg::ST_FULL) full_drops++;
    if (predicted.st == prq_pkg::ST_EMPTY) empty_pops++;
  endtask

  // Lower valid for a gap; never in the step that raises it again
  task automatic sender_gap(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Result side: compare each beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat, task", popped_task, 8'h00);
      end else begin
        queue_result_t want;
        want = pending_results.pop_front();
        if (popped_task !== want.tid) report_mismatch("task", popped_task, want.tid);
        if (popped_priority !== want.lvl)
          report_mismatch("priority", {4'd0, popped_priority}, {4'd0, want.lvl});
        if (status !== want.st) report_mismatch("status", {6'd0, status}, {6'd0, want.st});
      end
      results_seen++;
    end
  end

  // Result-side stall patterns, switched at random
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(3));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(3) != 0);
      default:  out_stall <= (rx_left % 16) < 9;
    endcase
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no beat for %0d cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int           random_sent;
    int           burst_left;
    int           chunk_len;
    int           pick;
    logic         gaps_on;
    logic         first_chunk;
    mix_t         mix;
    prq_pkg::op_t code;
    logic [3:0]   hot_a;
    logic [3:0]   hot_b;
    logic [3:0]   lvl;
    step_row_t    row;

    for (int l = 0; l < LEVELS; l++) begin
      ring_head[l] = 0;
      ring_tail[l] = 0;
      ring_fill[l] = 0;
    end
    tasks_held  = 0;
    top_lvl     = 0;
    random_sent = 0;
    burst_left  = 0;
    first_chunk = 1'b1;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      for (int k = 0; k < row.reps; k++)
        send_request(row.code, row.tid + k[7:0], row.lvl, row.typed,
                     '{row.want_tid, row.want_lvl, row.want_st});
    end

    // Random phases
    while (random_sent < RANDOM_ITEMS) begin
      chunk_len = $urandom_range(40, 120);
      mix       = mix_t'($urandom_range(2));
      gaps_on   = ($urandom_range(3) != 0);
      hot_a     = 4'($urandom_range(15));
      hot_b     = 4'($urandom_range(15));
      // let the queue settle completely now and then
      if (first_chunk || $urandom_range(3) == 0) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        first_chunk = 1'b0;
      end
      repeat (chunk_len) begin
        pick = $urandom_range(99);
        case (mix)
          MIX_FILL:  code = pick < 60 ? prq_pkg::OP_PUSH : pick < 85 ? prq_pkg::OP_PREEMPT :
                            pick < 97 ? prq_pkg::OP_POP : prq_pkg::OP_NONE;
          MIX_DRAIN: code = pick < 15 ? prq_pkg::OP_PUSH : pick < 22 ? prq_pkg::OP_PREEMPT :
                            pick < 97 ? prq_pkg::OP_POP : prq_pkg::OP_NONE;
          default:   code = pick < 35 ? prq_pkg::OP_PUSH : pick < 50 ? prq_pkg::OP_PREEMPT :
                            pick < 95 ? prq_pkg::OP_POP : prq_pkg::OP_NONE;
        endcase
        // fill phases crowd a couple of levels so they run full
        if (mix == MIX_FILL && $urandom_range(4) != 0)
          lvl = $urandom_range(1) ? hot_a : hot_b;
        else
          lvl = 4'($urandom_range(15));
        send_request(code, 8'($urandom_range(255)), lvl, 1'b0, '0);
        if (code != prq_pkg::OP_NONE) random_sent++;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          sender_gap(gaps_on ? $urandom_range(1, 6) : 0);
        end else begin
          burst_left--;
        end
      end
    end

    // Drain and let the block settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d served pops, %0d full drops, %0d empty pops)",
             beats_sent, pops_served, full_drops, empty_pops);
    $display("Checked %0d result beats, %0d field mismatches", results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
